### hw/rtl/cclr_pkg.sv
// Shared types and constants of the cell canvas line and rectangle drawer.
package cclr_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned CellW  = 34;

  localparam logic [2:0] OpPoint = 3'd0;
  localparam logic [2:0] OpLine  = 3'd1;
  localparam logic [2:0] OpRect  = 3'd2;
  localparam logic [2:0] OpFill  = 3'd3;
  localparam logic [2:0] OpRead  = 3'd4;

  localparam logic [2:0] ModeFull   = 3'd0;
  localparam logic [2:0] ModeHalfV  = 3'd1;
  localparam logic [2:0] ModeHalfH  = 3'd2;
  localparam logic [2:0] ModeQuart  = 3'd3;
  localparam logic [2:0] ModeText   = 3'd4;

  localparam logic [2:0] RegPixelMode  = 3'd0;
  localparam logic [2:0] RegDrawColour = 3'd1;
  localparam logic [2:0] RegXHalf      = 3'd2;
  localparam logic [2:0] RegYHalf      = 3'd3;
  localparam logic [2:0] RegActCols    = 3'd4;
  localparam logic [2:0] RegActRows    = 3'd5;

  localparam logic [3:0] MaskLeft  = 4'h5;
  localparam logic [3:0] MaskRight = 4'hA;
  localparam logic [3:0] MaskAll   = 4'hF;

  typedef struct packed {
    logic       up_on;
    logic       lo_on;
    logic [3:0] up_col;
    logic [3:0] lo_col;
    logic [3:0] qmask;
    logic [3:0] qcol;
    logic [7:0] tcode;
    logic [3:0] tcol;
    logic [3:0] tback;
  } cell_t;

  typedef struct packed {
    logic [2:0] operation;
    logic signed [CoordW-1:0] x_start;
    logic signed [CoordW-1:0] y_start;
    logic signed [CoordW-1:0] x_end;
    logic signed [CoordW-1:0] y_end;
    logic       set_on;
    logic [3:0] fill_colour;
  } cmd_t;

  typedef struct packed {
    logic       done_res;
    cell_t      cval;
  } res_t;

  typedef struct packed {
    logic [2:0] pixel_mode;
    logic [3:0] draw_colour;
    logic       x_half;
    logic       y_half;
  } cfg_t;

  // Point request from the walker to the cell updater.
  typedef struct packed {
    logic                     vld;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } pt_t;

endpackage

### hw/rtl/cclr_if.sv
// Valid/ready channel interface carrying one payload.
interface cclr_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/cell_canvas_line_rect_drawer.sv
// Top level of the cell canvas line and rectangle drawer.
// Each request carries one command: plot a point, draw a Bresenham line, draw a
// rectangle outline, fill one cell or read one cell back; each command returns one
// result. Cells live in a synchronous RAM of MaxCols x MaxRows entries and every
// plotted point is a read-modify-write of one cell (read, then write). The next
// request is taken in the cycle after the result has been taken. A point, fill or
// read has one point; a line has longest axis + 1 points, and a rectangle
// 2 x (width + height + 2) points, width and height being the corner differences.
// After reset a clearing pass writes every cell blank, one per cycle; no request is
// taken meanwhile, while configuration writes are taken at any time.
// Out-of-canvas points are skipped but still cost their step.
module cell_canvas_line_rect_drawer #(
  parameter int unsigned MaxCols = 128,
  parameter int unsigned MaxRows = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  cclr_if.sink       cmd_if,
  cclr_if.source     res_if
);
  localparam int unsigned ColW  = $clog2(MaxCols);
  localparam int unsigned RowW  = $clog2(MaxRows);
  localparam int unsigned Depth = MaxCols * MaxRows;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned W     = cclr_pkg::CoordW;

  // Configuration registers.
  cclr_pkg::cfg_t cfg_q;
  logic [7:0] cols_q;
  logic [6:0] rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_mode <= cclr_pkg::ModeFull;
      cfg_q.draw_colour <= 4'hF;
      cfg_q.x_half <= 1'b0;
      cfg_q.y_half <= 1'b0;
      cols_q <= 8'd128;
      rows_q <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cclr_pkg::RegPixelMode:  cfg_q.pixel_mode <= cfg_data_i[2:0];
        cclr_pkg::RegDrawColour: cfg_q.draw_colour <= cfg_data_i[3:0];
        cclr_pkg::RegXHalf:      cfg_q.x_half <= cfg_data_i[0];
        cclr_pkg::RegYHalf:      cfg_q.y_half <= cfg_data_i[0];
        cclr_pkg::RegActCols:    cols_q <= cfg_data_i;
        cclr_pkg::RegActRows:    rows_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Control sequencer.
  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SRead  = 3'd2;
  localparam logic [2:0] SMod   = 3'd3;
  localparam logic [2:0] SOut   = 3'd4;

  logic [2:0]  st_q, st_d;
  logic [AW:0] clr_q, clr_d;
  cclr_pkg::cmd_t cmd_q;
  cclr_pkg::res_t res_q, res_d;
  logic        res_vld_q, res_vld_d;
  logic        hit_q, hit_d;
  logic [AW-1:0] addr_q, addr_d;

  cclr_pkg::pt_t pt;
  logic        wk_busy, wk_start, wk_adv;

  cclr_walker u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wk_start),
    .cmd_i   (cmd_if.data),
    .adv_i   (wk_adv),
    .pt_o    (pt),
    .busy_o  (wk_busy)
  );

  // Bounds check against the clipped active size.
  logic [10:0] wlim, hlim;
  logic        in_bounds;
  always_comb begin
    wlim = (11'(cols_q) > 11'(MaxCols)) ? 11'(MaxCols) : 11'(cols_q);
    hlim = (11'(rows_q) > 11'(MaxRows)) ? 11'(MaxRows) : 11'(rows_q);
    in_bounds = !pt.x[W-1] && !pt.y[W-1] && (pt.x[10:0] < wlim) && (pt.y[10:0] < hlim);
  end

  cclr_pkg::cell_t rdata, wcell;
  logic          we;
  logic [AW-1:0] waddr;
  logic [cclr_pkg::CellW-1:0] wdata, rraw;

  cclr_ram #(.Width(cclr_pkg::CellW), .Depth(Depth)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (addr_d),
    .rdata_o (rraw)
  );
  assign rdata = cclr_pkg::cell_t'(rraw);

  // Write rules of one plotted point, or of a fill.
  logic [3:0] bitm;
  always_comb begin
    wcell = rdata;
    bitm = cfg_q.x_half ? cclr_pkg::MaskRight : cclr_pkg::MaskLeft;
    if (cfg_q.pixel_mode == cclr_pkg::ModeQuart) begin
      bitm = cfg_q.y_half ? (cfg_q.x_half ? 4'h8 : 4'h4) : (cfg_q.x_half ? 4'h2 : 4'h1);
    end
    if (cmd_q.operation == cclr_pkg::OpFill) begin
      wcell.up_on = 1'b1; wcell.lo_on = 1'b1;
      wcell.up_col = cmd_q.fill_colour; wcell.lo_col = cmd_q.fill_colour;
      wcell.qmask = cclr_pkg::MaskAll; wcell.qcol = cmd_q.fill_colour;
      wcell.tcode = '0;
    end else begin
      unique case (cfg_q.pixel_mode)
        cclr_pkg::ModeFull, cclr_pkg::ModeText: begin
          wcell.up_on = cmd_q.set_on; wcell.lo_on = cmd_q.set_on;
          wcell.up_col = cfg_q.draw_colour; wcell.lo_col = cfg_q.draw_colour;
        end
        cclr_pkg::ModeHalfV: begin
          if (!cfg_q.y_half) begin
            wcell.up_on = cmd_q.set_on; wcell.up_col = cfg_q.draw_colour;
          end else begin
            wcell.lo_on = cmd_q.set_on; wcell.lo_col = cfg_q.draw_colour;
          end
        end
        cclr_pkg::ModeHalfH, cclr_pkg::ModeQuart: begin
          if (cmd_q.set_on) begin
            wcell.qmask = rdata.qmask | bitm; wcell.qcol = cfg_q.draw_colour;
          end else begin
            wcell.qmask = rdata.qmask & ~bitm;
          end
        end
        default: ;
      endcase
    end
  end

  logic is_write;
  assign is_write = cmd_q.operation == cclr_pkg::OpPoint || cmd_q.operation == cclr_pkg::OpLine
                 || cmd_q.operation == cclr_pkg::OpRect || cmd_q.operation == cclr_pkg::OpFill;

  always_comb begin
    we    = 1'b0;
    waddr = addr_q;
    wdata = wcell;
    if (st_q == SClear) begin
      we = 1'b1; waddr = clr_q[AW-1:0]; wdata = '0;
    end else if (st_q == SMod && hit_q && is_write) begin
      we = 1'b1;
    end
  end

  assign cmd_if.ready = (st_q == SIdle) && !res_vld_q;
  assign wk_start     = cmd_if.valid && cmd_if.ready;

  always_comb begin
    st_d = st_q; clr_d = clr_q; res_d = res_q; res_vld_d = res_vld_q;
    hit_d = hit_q; addr_d = addr_q; wk_adv = 1'b0;
    if (res_if.valid && res_if.ready) begin
      res_vld_d = 1'b0;
    end
    unique case (st_q)
      SClear: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == (AW+1)'(Depth - 1)) begin
          st_d = SIdle;
        end
      end
      SIdle: begin
        if (wk_start) begin
          st_d = SRead;
          res_d = '0;
          res_d.done_res = 1'b1;
        end
      end
      SRead: begin
        // Walker holds the current point; issue the cell read.
        if (!wk_busy) begin
          st_d = SOut;
        end else begin
          hit_d  = in_bounds;
          addr_d = AW'(32'(pt.y[RowW-1:0]) * MaxCols + 32'(pt.x[ColW-1:0]));
          wk_adv = 1'b1;
          st_d = SMod;
        end
      end
      SMod: begin
        if (hit_q && cmd_q.operation == cclr_pkg::OpRead) begin
          res_d.cval = rdata;
        end
        st_d = SRead;
      end
      SOut: begin
        res_vld_d = 1'b1;
        st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SClear;
      clr_q <= '0;
      res_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      clr_q <= clr_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    hit_q <= hit_d;
    addr_q <= addr_d;
    if (wk_start) begin
      cmd_q <= cmd_if.data;
    end
  end

  assign res_if.valid = res_vld_q;
  assign res_if.data  = res_q;
endmodule

### hw/rtl/cclr_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
module cclr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### hw/rtl/cclr_walker.sv
// Point sequencer: walks Bresenham lines and rectangle outlines one point per step.
module cclr_walker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  cclr_pkg::cmd_t cmd_i,
  input  logic          adv_i,
  output cclr_pkg::pt_t pt_o,
  output logic          busy_o
);
  localparam int unsigned W  = cclr_pkg::CoordW;
  localparam int unsigned EW = W + 3;
  localparam logic signed [W:0] One = (W+1)'(1);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SLine = 3'd1;
  localparam logic [2:0] SRh   = 3'd2;
  localparam logic [2:0] SRv   = 3'd3;
  localparam logic [2:0] SOne  = 3'd4;

  logic [2:0] st_q, st_d;
  logic signed [W:0]    x_q, x_d, y_q, y_d, x1_q, x1_d, y1_q, y1_d;
  logic signed [W:0]    xa_q, xa_d, ya_q, ya_d, xb_q, xb_d, yb_q, yb_d;
  logic signed [EW-1:0] dx_q, dx_d, dy_q, dy_d, err_q, err_d;
  logic                 sx_q, sx_d, sy_q, sy_d, side_q, side_d;
  logic signed [EW-1:0] e2;
  logic signed [W:0]    xs, ys, xe, ye;

  assign xs = {cmd_i.x_start[W-1], cmd_i.x_start};
  assign ys = {cmd_i.y_start[W-1], cmd_i.y_start};
  assign xe = {cmd_i.x_end[W-1], cmd_i.x_end};
  assign ye = {cmd_i.y_end[W-1], cmd_i.y_end};
  assign e2 = err_q <<< 1;

  always_comb begin
    st_d = st_q; x_d = x_q; y_d = y_q; x1_d = x1_q; y1_d = y1_q;
    xa_d = xa_q; ya_d = ya_q; xb_d = xb_q; yb_d = yb_q;
    dx_d = dx_q; dy_d = dy_q; err_d = err_q; sx_d = sx_q; sy_d = sy_q;
    side_d = side_q;
    if (start_i) begin
      x_d = xs; y_d = ys; x1_d = xe; y1_d = ye; side_d = 1'b0;
      dx_d = (xe > xs) ? EW'(xe - xs) : EW'(xs - xe);
      dy_d = (ye > ys) ? EW'(ys - ye) : EW'(ye - ys);
      err_d = ((xe > xs) ? EW'(xe - xs) : EW'(xs - xe))
            + ((ye > ys) ? EW'(ys - ye) : EW'(ye - ys));
      sx_d = xs < xe; sy_d = ys < ye;
      xa_d = (xs > xe) ? xe : xs; xb_d = (xs > xe) ? xs : xe;
      ya_d = (ys > ye) ? ye : ys; yb_d = (ys > ye) ? ys : ye;
      unique case (cmd_i.operation)
        cclr_pkg::OpLine: st_d = SLine;
        cclr_pkg::OpRect: begin
          st_d = SRh;
          x_d = (xs > xe) ? xe : xs;
          y_d = (ys > ye) ? ye : ys;
        end
        default: st_d = SOne;
      endcase
    end else if (adv_i) begin
      unique case (st_q)
        SLine: begin
          if (x_q == x1_q && y_q == y1_q) begin
            st_d = SIdle;
          end else begin
            if (e2 >= dy_q) begin
              x_d = sx_q ? x_q + One : x_q - One;
            end
            if (e2 <= dx_q) begin
              y_d = sy_q ? y_q + One : y_q - One;
            end
            err_d = err_q + ((e2 >= dy_q) ? dy_q : '0) + ((e2 <= dx_q) ? dx_q : '0);
          end
        end
        SRh: begin
          // Alternate top and bottom edge for each column.
          if (!side_q) begin
            side_d = 1'b1; y_d = yb_q;
          end else begin
            side_d = 1'b0; y_d = ya_q;
            if (x_q == xb_q) begin
              st_d = SRv; x_d = xa_q;
            end else begin
              x_d = x_q + One;
            end
          end
        end
        SRv: begin
          if (!side_q) begin
            side_d = 1'b1; x_d = xb_q;
          end else begin
            side_d = 1'b0; x_d = xa_q;
            if (y_q == yb_q) begin
              st_d = SIdle;
            end else begin
              y_d = y_q + One;
            end
          end
        end
        SOne:    st_d = SIdle;
        default: st_d = SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; x1_q <= x1_d; y1_q <= y1_d;
    xa_q <= xa_d; ya_q <= ya_d; xb_q <= xb_d; yb_q <= yb_d;
    dx_q <= dx_d; dy_q <= dy_d; err_q <= err_d;
    sx_q <= sx_d; sy_q <= sy_d; side_q <= side_d;
  end

  assign busy_o   = st_q != SIdle;
  assign pt_o.vld = st_q != SIdle;
  assign pt_o.x   = x_q[W-1:0];
  assign pt_o.y   = y_q[W-1:0];
endmodule

### dv/tb.sv
// Self-checking bench for the cell canvas line and rectangle drawer.
module tb;

  localparam int unsigned Cols = 128;
  localparam int unsigned Rows = 64;
  // Longest command is a rectangle spanning the whole 12-bit range.
  localparam int unsigned StallLimit = 200000;

  logic clk_i;
  logic rst_ni;
  logic       cfg_we;
  logic [2:0] cfg_idx;
  logic [7:0] cfg_data;

  cclr_if #(.T(cclr_pkg::cmd_t)) cmd_if ();
  cclr_if #(.T(cclr_pkg::res_t)) res_if ();

  cell_canvas_line_rect_drawer i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .cmd_if    (cmd_if),
    .res_if    (res_if)
  );

  // Mirror of the canvas and of the configuration registers.
  cclr_pkg::cell_t canvas [Cols*Rows];
  logic [2:0] mode_q;
  logic [3:0] colour_q;
  logic       xh_q;
  logic       yh_q;
  logic [7:0] cols_q;
  logic [6:0] rows_q;

  cclr_pkg::res_t pending_res [$];
  int   n_err;
  int   n_cmds;
  int   n_reads;
  int   idle_cnt;
  int   send_idle_pct;
  int   recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Looks up a cell; returns -1 when the point lies off the active canvas.
  function automatic int cell_index(int x, int y);
    int w;
    int h;
    w = (int'(cols_q) > int'(Cols)) ? int'(Cols) : int'(cols_q);
    h = (int'(rows_q) > int'(Rows)) ? int'(Rows) : int'(rows_q);
    if (x < 0 || y < 0 || x >= w || y >= h) return -1;
    return y * int'(Cols) + x;
  endfunction

  // Applies the write rules of the current pixel mode to one point.
  function automatic void plot_point(int x, int y, logic on);
    int         k;
    logic [3:0] bits;
    k = cell_index(x, y);
    if (k < 0) return;
    case (mode_q)
      cclr_pkg::ModeFull, cclr_pkg::ModeText: begin
        canvas[k].up_on  = on;
        canvas[k].lo_on  = on;
        canvas[k].up_col = colour_q;
        canvas[k].lo_col = colour_q;
      end
      cclr_pkg::ModeHalfV: begin
        if (!yh_q) begin
          canvas[k].up_on  = on;
          canvas[k].up_col = colour_q;
        end else begin
          canvas[k].lo_on  = on;
          canvas[k].lo_col = colour_q;
        end
      end
      cclr_pkg::ModeHalfH, cclr_pkg::ModeQuart: begin
        if (mode_q == cclr_pkg::ModeHalfH) bits = xh_q ? cclr_pkg::MaskRight : cclr_pkg::MaskLeft;
        else bits = (yh_q ? 4'd4 : 4'd1) << xh_q;
        if (on) begin
          canvas[k].qmask = canvas[k].qmask | bits;
          canvas[k].qcol  = colour_q;
        end else begin
          canvas[k].qmask = canvas[k].qmask & ~bits;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void trace_line(int x0, int y0, int x1, int y1, logic on);
    int dx;
    int dy;
    int sx;
    int sy;
    int err;
    int e2;
    dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy  = -((y1 > y0) ? y1 - y0 : y0 - y1);
    sx  = (x0 < x1) ? 1 : -1;
    sy  = (y0 < y1) ? 1 : -1;
    err = dx + dy;
    forever begin
      plot_point(x0, y0, on);
      if (x0 == x1 && y0 == y1) break;
      e2 = 2 * err;
      if (e2 >= dy) begin
        err += dy;
        x0  += sx;
      end
      if (e2 <= dx) begin
        err += dx;
        y0  += sy;
      end
    end
  endfunction

  function automatic void trace_rect(int x0, int y0, int x1, int y1, logic on);
    int t;
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
    end
    if (y0 > y1) begin
      t = y0; y0 = y1; y1 = t;
    end
    for (int i = x0; i <= x1; i++) begin
      plot_point(i, y0, on);
      plot_point(i, y1, on);
    end
    for (int i = y0; i <= y1; i++) begin
      plot_point(x0, i, on);
      plot_point(x1, i, on);
    end
  endfunction

  // Updates the canvas mirror for one command and returns the result it must give.
  function automatic cclr_pkg::res_t canvas_after(cclr_pkg::cmd_t c);
    cclr_pkg::res_t r;
    int   k;
    r          = '0;
    r.done_res = 1'b1;
    case (c.operation)
      cclr_pkg::OpPoint: plot_point(c.x_start, c.y_start, c.set_on);
      cclr_pkg::OpLine:  trace_line(c.x_start, c.y_start, c.x_end, c.y_end, c.set_on);
      cclr_pkg::OpRect:  trace_rect(c.x_start, c.y_start, c.x_end, c.y_end, c.set_on);
      cclr_pkg::OpFill: begin
        k = cell_index(c.x_start, c.y_start);
        if (k >= 0) begin
          canvas[k].up_on  = 1'b1;
          canvas[k].lo_on  = 1'b1;
          canvas[k].up_col = c.fill_colour;
          canvas[k].lo_col = c.fill_colour;
          canvas[k].qmask  = cclr_pkg::MaskAll;
          canvas[k].qcol   = c.fill_colour;
          canvas[k].tcode  = '0;
        end
      end
      cclr_pkg::OpRead: begin
        k = cell_index(c.x_start, c.y_start);
        if (k >= 0) r.cval = canvas[k];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    n_err++;
  endtask

  // Writes one register at a falling edge and keeps the mirror in step.
  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      cclr_pkg::RegPixelMode:  mode_q   = val[2:0];
      cclr_pkg::RegDrawColour: colour_q = val[3:0];
      cclr_pkg::RegXHalf:      xh_q     = val[0];
      cclr_pkg::RegYHalf:      yh_q     = val[0];
      cclr_pkg::RegActCols:    cols_q   = val;
      cclr_pkg::RegActRows:    rows_q   = val[6:0];
      default: ;
    endcase
  endtask

  // Sends one request; the expectation is formed when it is accepted. Entered and
  // left at a falling edge; valid stays high into the next request unless idling.
  task automatic send_cmd(cclr_pkg::cmd_t c);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= c;
    do @(posedge clk_i); while (!cmd_if.ready);
    pending_res.push_back(canvas_after(c));
    n_cmds++;
    if (c.operation == cclr_pkg::OpRead) n_reads++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    cmd_if.valid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic cclr_pkg::cmd_t make_cmd(logic [2:0] op, int xs, int ys, int xe,
                                              int ye, logic on, logic [3:0] fc);
    cclr_pkg::cmd_t c;
    c.operation   = op;
    c.x_start     = 12'(xs);
    c.y_start     = 12'(ys);
    c.x_end       = 12'(xe);
    c.y_end       = 12'(ye);
    c.set_on      = on;
    c.fill_colour = fc;
    return c;
  endfunction

  // Small coordinates mostly, so that drawing stays on the canvas and short.
  function automatic int rand_coord(int span);
    int p;
    p = $urandom_range(99);
    if (p < 85) return int'($urandom_range(span - 1));
    if (p < 95) return int'($urandom_range(span + 8)) - 4;
    return int'($signed(12'($urandom)));
  endfunction

  function automatic cclr_pkg::cmd_t rand_cmd(int span);
    cclr_pkg::cmd_t c;
    int   p;
    c.x_start = 12'(rand_coord(span));
    c.y_start = 12'(rand_coord(span));
    p = $urandom_range(99);
    if (p < 97) begin
      c.x_end = 12'(int'(c.x_start) + int'($urandom_range(16)) - 8);
      c.y_end = 12'(int'(c.y_start) + int'($urandom_range(16)) - 8);
    end else begin
      c.x_end = 12'($urandom);
      c.y_end = 12'($urandom);
    end
    p = $urandom_range(99);
    if (p < 25) c.operation = cclr_pkg::OpPoint;
    else if (p < 45) c.operation = cclr_pkg::OpLine;
    else if (p < 55) c.operation = cclr_pkg::OpRect;
    else if (p < 65) c.operation = cclr_pkg::OpFill;
    else if (p < 97) c.operation = cclr_pkg::OpRead;
    else c.operation = 3'($urandom_range(7, 5));
    c.set_on      = 1'($urandom_range(1));
    c.fill_colour = 4'($urandom_range(15));
    return c;
  endfunction

  // Extreme coordinates, every operation and two of the unused codes, at reset settings.
  task automatic test_directed();
    send_cmd(make_cmd(cclr_pkg::OpRead, 0, 0, 0, 0, 1'b0, 4'd0));
    send_cmd(make_cmd(cclr_pkg::OpPoint, 0, 0, 0, 0, 1'b1, 4'd0));
    send_cmd(make_cmd(cclr_pkg::OpPoint, 127, 63, 0, 0, 1'b1, 4'd0));
    send_cmd(make_cmd(cclr_pkg::OpPoint, -1, 5, 0, 0, 1'b1, 4'd0));
    send_cmd(make_cmd(cclr_pkg::OpPoint, 128, 64, 0, 0, 1'b1, 4'd0));
    send_cmd(make_cmd(cclr_pkg::OpLine, 2, 3, 20, 9, 1'b1, 4'd0));
    send_cmd(make_cmd(cclr_pkg::OpLine, 20, 9, 2, 30, 1'b0, 4'd0));
    send_cmd(make_cmd(cclr_pkg::OpLine, -3, -3, 4, 4, 1'b1, 4'd0));
    send_cmd(make_cmd(cclr_pkg::OpRect, 10, 12, 4, 5, 1'b1, 4'd0));
    send_cmd(make_cmd(cclr_pkg::OpRect, 125, 60, 130, 66, 1'b1, 4'd0));
    send_cmd(make_cmd(cclr_pkg::OpFill, 7, 7, 0, 0, 1'b0, 4'd9));
    send_cmd(make_cmd(cclr_pkg::OpFill, -2048, 2047, 0, 0, 1'b0, 4'd15));
    send_cmd(make_cmd(cclr_pkg::OpRead, 7, 7, -2048, 2047, 1'b1, 4'd15));
    send_cmd(make_cmd(cclr_pkg::OpRead, 127, 63, 0, 0, 1'b0, 4'd0));
    send_cmd(make_cmd(cclr_pkg::OpRead, 2047, -2048, 0, 0, 1'b0, 4'd0));
    send_cmd(make_cmd(cclr_pkg::OpRead, 10, 12, 0, 0, 1'b0, 4'd0));
    send_cmd(make_cmd(3'd5, 1, 1, 0, 0, 1'b1, 4'd3));
    send_cmd(make_cmd(3'd7, 2047, 2047, 2047, 2047, 1'b1, 4'd15));
    // A line whose far end lies off in the negative corner: long but bounded.
    send_cmd(make_cmd(cclr_pkg::OpLine, 5, 5, -600, -300, 1'b1, 4'd0));
    send_cmd(make_cmd(cclr_pkg::OpRead, 4, 4, 0, 0, 1'b0, 4'd0));
    drain();
  endtask

  // Random commands under one configuration, then a sweep of reads to expose the canvas.
  task automatic test_random(int n, int span);
    for (int i = 0; i < n; i++) send_cmd(rand_cmd(span));
    for (int i = 0; i < 6; i++)
      send_cmd(make_cmd(cclr_pkg::OpRead, int'($urandom_range(span - 1)),
                        int'($urandom_range(span - 1)), 0, 0, 1'b0, 4'd0));
    drain();
  endtask

  task automatic test_modes();
    for (int m = 0; m < 8; m++) begin
      write_reg(cclr_pkg::RegPixelMode, 8'(m));
      write_reg(cclr_pkg::RegDrawColour, 8'($urandom_range(15)));
      write_reg(cclr_pkg::RegXHalf, 8'($urandom_range(1)));
      write_reg(cclr_pkg::RegYHalf, 8'($urandom_range(1)));
      test_random(40, 12);
    end
  endtask

  task automatic test_sizes();
    write_reg(cclr_pkg::RegPixelMode, 8'(cclr_pkg::ModeQuart));
    write_reg(cclr_pkg::RegActCols, 8'd1);
    write_reg(cclr_pkg::RegActRows, 8'd1);
    test_random(30, 4);
    write_reg(cclr_pkg::RegActCols, 8'd255);
    write_reg(cclr_pkg::RegActRows, 8'd127);
    write_reg(cclr_pkg::RegPixelMode, 8'(cclr_pkg::ModeHalfH));
    test_random(30, 12);
    write_reg(cclr_pkg::RegActCols, 8'd0);
    test_random(15, 6);
    write_reg(cclr_pkg::RegActCols, 8'd20);
    write_reg(cclr_pkg::RegActRows, 8'd0);
    test_random(15, 6);
    write_reg(cclr_pkg::RegActRows, 8'd10);
    write_reg(cclr_pkg::RegPixelMode, 8'(cclr_pkg::ModeHalfV));
    test_random(40, 24);
    write_reg(cclr_pkg::RegActCols, 8'd128);
    write_reg(cclr_pkg::RegActRows, 8'd64);
    write_reg(cclr_pkg::RegPixelMode, 8'(cclr_pkg::ModeFull));
  endtask

  task automatic test_idling();
    send_idle_pct = 51;
    test_random(60, 16);
    send_idle_pct  = 0;
    recv_stall_pct = 51;
    write_reg(cclr_pkg::RegPixelMode, 8'(cclr_pkg::ModeQuart));
    test_random(60, 16);
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    write_reg(cclr_pkg::RegPixelMode, 8'(cclr_pkg::ModeText));
    test_random(60, 16);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Result checker: compares every accepted result with the oldest expectation.
  initial begin
    cclr_pkg::res_t got;
    cclr_pkg::res_t want;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        got = res_if.data;
        if (pending_res.size() == 0) begin
          report("unexpected result", 32'(got), 32'd0);
        end else begin
          want = pending_res.pop_front();
          if (got.done_res !== want.done_res)
            report("done", 32'(got.done_res), 32'(want.done_res));
          if (got.cval.up_on !== want.cval.up_on)
            report("upper_on", 32'(got.cval.up_on), 32'(want.cval.up_on));
          if (got.cval.lo_on !== want.cval.lo_on)
            report("lower_on", 32'(got.cval.lo_on), 32'(want.cval.lo_on));
          if (got.cval.up_col !== want.cval.up_col)
            report("upper_colour", 32'(got.cval.up_col), 32'(want.cval.up_col));
          if (got.cval.lo_col !== want.cval.lo_col)
            report("lower_colour", 32'(got.cval.lo_col), 32'(want.cval.lo_col));
          if (got.cval.qmask !== want.cval.qmask)
            report("quarter_mask", 32'(got.cval.qmask), 32'(want.cval.qmask));
          if (got.cval.qcol !== want.cval.qcol)
            report("quarter_colour", 32'(got.cval.qcol), 32'(want.cval.qcol));
          if (got.cval.tcode !== want.cval.tcode)
            report("text_code", 32'(got.cval.tcode), 32'(want.cval.tcode));
          if (got.cval.tcol !== want.cval.tcol)
            report("text_colour", 32'(got.cval.tcol), 32'(want.cval.tcol));
          if (got.cval.tback !== want.cval.tback)
            report("text_back", 32'(got.cval.tback), 32'(want.cval.tback));
        end
      end
    end
  end

  // Watchdog: the clearing pass after reset and long lines both fit well inside the limit.
  initial begin
    idle_cnt = 0;
    forever begin
      @(posedge clk_i);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= StallLimit) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    cmd_if.valid   = 1'b0;
    cmd_if.data    = '0;
    n_err          = 0;
    n_cmds         = 0;
    n_reads        = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (canvas[k]) canvas[k] = '0;
    mode_q   = cclr_pkg::ModeFull;
    colour_q = 4'd15;
    xh_q     = 1'b0;
    yh_q     = 1'b0;
    cols_q   = 8'd128;
    rows_q   = 7'd64;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_modes();
    test_sizes();
    test_idling();
    // The sender holds off here until every result has returned.
    drain();
    test_random(40, 10);

    $display("covered %0d commands, %0d cell reads, all pixel modes and canvas sizes",
             n_cmds, n_reads);
    if (n_err == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
